### rtl/fen_to_hex_encoder_defines.svh
// assertion macros for the position-string encoder modules, used by fth_out
// needs clk and rst_n in the module that uses them
`ifndef FEN_TO_HEX_ENCODER_DEFINES_SVH
`define FEN_TO_HEX_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FTH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fth assertion failed");
`define FTH_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fth reset assertion failed");
`else
`define FTH_ASSERT(lbl, prop)
`define FTH_ASSERT_RST(lbl, prop)
`endif

`endif

### rtl/fth_pkg.sv
// package for the position-string encoder: phase codes, characters, symbol tables
// used by fth_enc, fth_out and fen_to_hex_encoder
package fth_pkg;

  localparam logic [1:0] PH_BOARD = 2'd0;
  localparam logic [1:0] PH_SIDE  = 2'd1;
  localparam logic [1:0] PH_SKIP  = 2'd2;
  localparam logic [1:0] PH_EXTRA = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] DIGIT_OFS = 8'd4;
  localparam logic [7:0] CASE_OFS  = 8'd32;

  localparam int GRP_DEPTH = 4;

  typedef struct packed {
    logic [GRP_DEPTH-1:0][7:0] sym;
    logic [2:0]                cnt;
    logic                      last;
  } grp_t;

  function automatic logic [7:0] board_code(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h31:   r = 8'h30;
      8'h32:   r = 8'h31;
      8'h33:   r = 8'h32;
      8'h70:   r = 8'h33;
      8'h6E:   r = 8'h34;
      8'h62:   r = 8'h35;
      8'h72:   r = 8'h36;
      8'h71:   r = 8'h37;
      8'h6B:   r = 8'h39;
      8'h50:   r = 8'h61;
      8'h4E:   r = 8'h62;
      8'h42:   r = 8'h63;
      8'h52:   r = 8'h64;
      8'h51:   r = 8'h65;
      8'h4B:   r = 8'h66;
      default: r = 8'h38;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] extra_code(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'h61 && c <= 8'h68) begin
      r = c - 8'h30;
    end else if (c >= 8'h42 && c <= 8'h47) begin
      r = 8'h65;
    end else begin
      case (c)
        8'h2D:   r = 8'h30;
        8'h4B:   r = 8'h61;
        8'h51:   r = 8'h62;
        8'h6B:   r = 8'h63;
        8'h71:   r = 8'h64;
        8'h20:   r = 8'h39;
        default: r = c;
      endcase
    end
    return r;
  endfunction

endpackage

### rtl/fen_to_hex_encoder.sv
// top level of the position-string to hex-code encoder
// depends on fth_pkg, fth_enc and fth_out
//
//   port group | dir | payload           | handshake
//   in_        | in  | in_char, in_last  | in_valid / in_stall
//   out_       | out | out_char, out_last| out_valid / out_stall
//
// characters pass through the input register, encoding on the way into the group buffer
// each character yields 0..4 symbols, one leaves per cycle through the output register while out_stall is low
// a character is taken every cycle while its group has at most one symbol and out_stall is low
// rst_n is synchronous and clears the phase, held symbol and all valid flags
// out_stall backs up into the group buffer and then into in_stall
module fen_to_hex_encoder import fth_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last
);

  logic       a_valid_r;
  logic [7:0] a_char_r;
  logic       a_last_r;
  logic       grp_ready;
  logic       a_take;
  logic       in_take;
  grp_t       grp;

  assign a_take   = a_valid_r && grp_ready;
  assign in_stall = a_valid_r && !grp_ready;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_take) begin
      a_valid_r <= 1'b1;
    end else if (a_take) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_char_r <= in_char;
      a_last_r <= in_last;
    end
  end

  fth_enc u_enc (
    .clk    (clk),
    .rst_n  (rst_n),
    .take_i (a_take),
    .char_i (a_char_r),
    .last_i (a_last_r),
    .grp_o  (grp)
  );

  fth_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .grp_valid_i (a_take),
    .grp_i       (grp),
    .grp_ready_o (grp_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .out_last    (out_last)
  );

endmodule

### rtl/fth_enc.sv
// encoder core: phase, held symbol and parity state, builds one symbol group per character
// depends on fth_pkg
module fth_enc import fth_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output grp_t       grp_o
);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r;
  logic       held_valid_r;
  logic       odd_r;

  logic [7:0] sym0, sym1;
  logic [1:0] ncnt;
  logic [GRP_DEPTH-1:0][7:0] sbuf;
  logic [2:0] n;
  logic [2:0] n_dec;
  logic       odd;

  always_comb begin
    sym0 = '0;
    sym1 = '0;
    ncnt = 2'd0;
    phase_nxt = phase_r;
    case (phase_r)
      PH_BOARD: begin
        if (char_i == CH_SPACE) begin
          phase_nxt = PH_SIDE;
          if (last_i) begin
            sym0 = CH_0;
            ncnt = 2'd1;
          end
        end else if (char_i != CH_SLASH) begin
          sym0 = board_code(char_i);
          ncnt = 2'd1;
          if (char_i >= CH_4 && char_i <= CH_8) begin
            sym1 = char_i - DIGIT_OFS;
            ncnt = 2'd2;
          end
        end
      end
      PH_SIDE: begin
        sym0 = (char_i == CH_LB) ? CH_1 : CH_0;
        ncnt = 2'd1;
        phase_nxt = PH_SKIP;
      end
      PH_SKIP: begin
        phase_nxt = PH_EXTRA;
      end
      default: begin
        sym0 = extra_code(char_i);
        ncnt = 2'd1;
        if (sym0 == CH_LE) begin
          sym1 = extra_code(char_i + CASE_OFS);
          ncnt = 2'd2;
        end
      end
    endcase
  end

  always_comb begin
    sbuf = '0;
    n = 3'd0;
    if (held_valid_r) begin
      sbuf[0] = held_r;
      n = 3'd1;
    end
    if (ncnt != 2'd0) begin
      sbuf[n[1:0]] = sym0;
      n = n + 3'd1;
    end
    if (ncnt == 2'd2) begin
      sbuf[n[1:0]] = sym1;
      n = n + 3'd1;
    end
    odd = odd_r ^ ncnt[0];
    n_dec = n - 3'd1;
    grp_o.last = last_i;
    if (last_i) begin
      if (odd && n != 3'd0) begin
        if (sbuf[n_dec[1:0]] == CH_0) begin
          n = n_dec;
        end else begin
          sbuf[n[1:0]] = CH_0;
          n = n + 3'd1;
        end
      end
      grp_o.cnt = n;
    end else begin
      grp_o.cnt = (n != 3'd0) ? n_dec : 3'd0;
    end
    grp_o.sym = sbuf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_BOARD;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      odd_r        <= 1'b0;
    end else if (take_i) begin
      if (last_i) begin
        phase_r      <= PH_BOARD;
        held_r       <= '0;
        held_valid_r <= 1'b0;
        odd_r        <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        odd_r   <= odd;
        if (n != 3'd0) begin
          held_r       <= sbuf[n_dec[1:0]];
          held_valid_r <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/fth_out.sv
// result drain: holds one symbol group and moves it out one symbol per transfer
// depends on fth_pkg and the assertion macro header
`include "fen_to_hex_encoder_defines.svh"

module fth_out import fth_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       grp_valid_i,
  input  grp_t       grp_i,
  output logic       grp_ready_o,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last
);

  logic [GRP_DEPTH-1:0][7:0] sym_r;
  logic [2:0] rem_r;
  logic       last_r;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;
  logic       ld, pop;

  assign ld  = !out_valid_r || !out_stall;
  assign pop = ld && (rem_r != 3'd0);
  assign grp_ready_o = (rem_r == 3'd0) || (rem_r == 3'd1 && pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= 3'd0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (grp_valid_i && grp_ready_o) begin
        rem_r  <= grp_i.cnt;
        last_r <= grp_i.last;
      end else if (pop) begin
        rem_r <= rem_r - 3'd1;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (ld) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_valid_i && grp_ready_o) begin
      sym_r <= grp_i.sym;
    end else if (pop) begin
      sym_r <= {8'd0, sym_r[GRP_DEPTH-1:1]};
    end
    if (pop) begin
      out_char_r <= sym_r[0];
      out_last_r <= last_r && (rem_r == 3'd1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  `FTH_ASSERT(a_rem_range, rem_r <= 3'd4)
  `FTH_ASSERT(a_grp_taken, grp_valid_i |-> grp_ready_o)
  `FTH_ASSERT_RST(a_rst_clears, !rst_n |=> !out_valid_r)

endmodule
